### sv/lmd_pkg.sv
// shared constants, types and helper functions of the local maximum detector
package lmd_pkg;

    localparam int MAX_WIDTH      = 2048;
    localparam int VALUE_BITS     = 16;
    localparam int ROW_LIMIT      = 2048;
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int ROW_BITS       = $clog2(ROW_LIMIT);
    localparam int DIM_BITS       = 12;
    localparam int BORDER_BITS    = 8;
    localparam int OUT_BITS       = 11;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;

    localparam int WCMP_BITS = (COL_BITS + 1 > DIM_BITS) ? COL_BITS + 1 : DIM_BITS;
    localparam int HCMP_BITS = (ROW_BITS + 1 > DIM_BITS) ? ROW_BITS + 1 : DIM_BITS;
    localparam int X_BITS    = ((COL_BITS > BORDER_BITS) ? COL_BITS : BORDER_BITS) + 1;
    localparam int Y_BITS    = ((ROW_BITS > BORDER_BITS) ? ROW_BITS : BORDER_BITS) + 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BORDER_SIZE  = 2'd2;

    localparam logic [DIM_BITS-1:0]    WIDTH_RESET  = 12'd640;
    localparam logic [DIM_BITS-1:0]    HEIGHT_RESET = 12'd480;
    localparam logic [BORDER_BITS-1:0] BORDER_RESET = 8'd20;

    // interest value in offset binary: unsigned order equals signed order
    typedef logic [VALUE_BITS-1:0] key_t;

    typedef struct packed {
        logic [COL_BITS:0]        width;
        logic [ROW_BITS:0]        height;
        logic [BORDER_BITS-1:0]   border;
    } geom_t;

    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
    } pos_t;

    function automatic key_t to_key(input logic signed [VALUE_BITS-1:0] v);
        return {~v[VALUE_BITS-1], v[VALUE_BITS-2:0]};
    endfunction

    function automatic logic [COL_BITS:0] clamp_width(input logic [DIM_BITS-1:0] v);
        logic [WCMP_BITS-1:0] ve;
        ve = WCMP_BITS'(v);
        if (ve < WCMP_BITS'(3))
            return (COL_BITS + 1)'(3);
        else if (ve > WCMP_BITS'(MAX_WIDTH))
            return (COL_BITS + 1)'(MAX_WIDTH);
        else
            return (COL_BITS + 1)'(ve);
    endfunction

    function automatic logic [ROW_BITS:0] clamp_height(input logic [DIM_BITS-1:0] v);
        logic [HCMP_BITS-1:0] ve;
        ve = HCMP_BITS'(v);
        if (ve < HCMP_BITS'(3))
            return (ROW_BITS + 1)'(3);
        else if (ve > HCMP_BITS'(ROW_LIMIT))
            return (ROW_BITS + 1)'(ROW_LIMIT);
        else
            return (ROW_BITS + 1)'(ve);
    endfunction

    function automatic logic [BORDER_BITS-1:0] clamp_border(input logic [BORDER_BITS-1:0] v);
        return (v == '0) ? BORDER_BITS'(1) : v;
    endfunction

endpackage

### sv/lmd_ifs.sv
// stream and configuration channel interfaces of the local maximum detector

interface lmd_pix_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [lmd_pkg::VALUE_BITS-1:0]   interest;
    logic                                    frame_start;

    modport source (output valid, output interest, output frame_start, input ready);
    modport sink   (input valid, input interest, input frame_start, output ready);
endinterface

interface lmd_feat_if;
    logic                              valid;
    logic                              ready;
    logic [lmd_pkg::OUT_BITS-1:0]      col;
    logic [lmd_pkg::OUT_BITS-1:0]      row;

    modport source (output valid, output col, output row, input ready);
    modport sink   (input valid, input col, input row, output ready);
endinterface

interface lmd_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic [lmd_pkg::CFG_INDEX_BITS-1:0]      index;
    logic [lmd_pkg::CFG_DATA_BITS-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/lmd_ram.sv
// generic single write port, single read port ram with registered read data
module lmd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

### sv/lmd_raster_pos.sv
// raster position tracking: column and row of each transferred pixel
module lmd_raster_pos (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           frame_start,
    input  lmd_pkg::geom_t geom,
    output lmd_pkg::pos_t  pos
);

    import lmd_pkg::*;

    logic [COL_BITS-1:0] col_count_reg, col_count_next;
    logic [ROW_BITS-1:0] row_count_reg, row_count_next;
    logic [COL_BITS-1:0] cc;
    logic [ROW_BITS-1:0] rr;
    logic [COL_BITS-1:0] c_cur;
    logic [ROW_BITS:0]   r_wrap;
    logic [ROW_BITS-1:0] r_cur;
    logic [COL_BITS:0]   c_inc;
    logic [ROW_BITS:0]   r_inc;

    always_comb
    begin
        cc = frame_start ? '0 : col_count_reg;
        rr = frame_start ? '0 : row_count_reg;

        // a column past a shrunk width ends the line at once
        if ({1'b0, cc} >= geom.width)
        begin
            c_cur  = '0;
            r_wrap = {1'b0, rr} + (ROW_BITS + 1)'(1);
        end
        else
        begin
            c_cur  = cc;
            r_wrap = {1'b0, rr};
        end
        r_cur = (r_wrap >= geom.height) ? '0 : r_wrap[ROW_BITS-1:0];

        c_inc = {1'b0, c_cur} + (COL_BITS + 1)'(1);
        r_inc = {1'b0, r_cur} + (ROW_BITS + 1)'(1);
        if (c_inc >= geom.width)
        begin
            col_count_next = '0;
            row_count_next = (r_inc >= geom.height) ? '0 : r_inc[ROW_BITS-1:0];
        end
        else
        begin
            col_count_next = c_inc[COL_BITS-1:0];
            row_count_next = r_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (advance)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    assign pos.col = c_cur;
    assign pos.row = r_cur;

endmodule

### sv/lmd_window.sv
// 3x3 window registers and the border and local maximum decision
module lmd_window (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift,
    input  lmd_pkg::key_t              top_key,
    input  lmd_pkg::key_t              mid_key,
    input  lmd_pkg::key_t              bot_key,
    input  lmd_pkg::pos_t              pos,
    input  lmd_pkg::geom_t             geom,
    output logic                       hit,
    output logic [lmd_pkg::OUT_BITS-1:0] hit_col,
    output logic [lmd_pkg::OUT_BITS-1:0] hit_row
);

    import lmd_pkg::*;

    // index is column * 3 + row, column 0 oldest
    key_t win_reg [9];
    key_t nw [9];
    key_t centre;
    logic [COL_BITS-1:0]    x;
    logic [ROW_BITS-1:0]    y;
    logic [X_BITS-1:0]      x_ext, bdx;
    logic [Y_BITS-1:0]      y_ext, bdy;
    logic [BORDER_BITS-1:0] bd;
    logic                   inside_area;
    logic                   is_max;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            nw[i] = win_reg[i + 3];
        end
        nw[6]  = top_key;
        nw[7]  = mid_key;
        nw[8]  = bot_key;
        centre = nw[4];

        is_max = 1'b1;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4 && nw[i] > centre)
            begin
                is_max = 1'b0;
            end
        end

        x     = pos.col - COL_BITS'(1);
        y     = pos.row - ROW_BITS'(1);
        bd    = clamp_border(geom.border);
        x_ext = X_BITS'(x);
        y_ext = Y_BITS'(y);
        bdx   = X_BITS'(bd);
        bdy   = Y_BITS'(bd);

        inside_area = (pos.col >= COL_BITS'(2)) && (pos.row >= ROW_BITS'(2))
                   && (x_ext >= bdx) && (x_ext + bdx < X_BITS'(geom.width))
                   && (y_ext >= bdy) && (y_ext + bdy < Y_BITS'(geom.height));

        hit     = inside_area && is_max;
        hit_col = OUT_BITS'(x);
        hit_row = OUT_BITS'(y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (shift)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= nw[i];
            end
        end
    end

endmodule

### sv/local_maximum_3x3_detector.sv
// top level of the 3x3 local maximum detector (non-maximum suppression)
module local_maximum_3x3_detector (
    input  logic       clk,
    input  logic       rst_n,
    lmd_cfg_if.sink    cfg,
    lmd_pix_if.sink    pix,
    lmd_feat_if.source feat
);

    // Takes one pixel per clock and, with the output draining, sustains one
    // pixel per cycle indefinitely. A pixel transfer computes the raster
    // position and reads both line stores; the next cycle holds the pixel in
    // the stage register, where the line stores are written back, the 3x3
    // window shifts and the decision is taken into the result register. A
    // feature is therefore presented from the edge after the transfer of the
    // pixel that completes its window (its lower-right neighbour), later only
    // while the output stalls. Features come
    // out in raster order, at most one per pixel. The line stores have no
    // reset or clearing pass: entries that were never written read as
    // unknown data, which only a width change inside a frame can expose.
    // Geometry and border are clamped to their legal ranges internally and
    // should only be written while no pixel is in flight.

    import lmd_pkg::*;

    // configuration registers
    logic [DIM_BITS-1:0]    width_reg;
    logic [DIM_BITS-1:0]    height_reg;
    logic [BORDER_BITS-1:0] border_reg;
    geom_t                  geom;

    // handshake and pipeline control
    logic pix_xfer;
    logic res_free;
    logic s1_adv;

    // pixel stage
    logic                s1_valid_reg;
    key_t                s1_key_reg;
    pos_t                s1_pos_reg;
    pos_t                pos;

    // line store read data and bypass for a read of the address being written
    key_t ram_a_q, ram_b_q;
    key_t a_eff, b_eff;
    logic fwd_hit_reg;
    key_t fwd_a_reg, fwd_b_reg;

    // window decision and result register
    logic                hit;
    logic [OUT_BITS-1:0] hit_col, hit_row;
    logic                res_valid_reg;
    logic [OUT_BITS-1:0] res_col_reg, res_row_reg;

    // configuration writes, always accepted
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            border_reg <= BORDER_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg.data[DIM_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg.data[DIM_BITS-1:0];
                REG_BORDER_SIZE:  border_reg <= cfg.data[BORDER_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign geom.width  = clamp_width(width_reg);
    assign geom.height = clamp_height(height_reg);
    assign geom.border = border_reg;

    // the stage moves on whenever the result register can take its outcome
    assign res_free  = !res_valid_reg || feat.ready;
    assign s1_adv    = s1_valid_reg && res_free;
    assign pix.ready = !s1_valid_reg || res_free;
    assign pix_xfer  = pix.valid && pix.ready;

    lmd_raster_pos u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (pix_xfer),
        .frame_start (pix.frame_start),
        .geom        (geom),
        .pos         (pos)
    );

    // line store a holds the previous row, b the row before that
    lmd_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store_a (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_pos_reg.col),
        .wdata (s1_key_reg),
        .re    (pix_xfer),
        .raddr (pos.col),
        .rdata (ram_a_q)
    );

    lmd_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store_b (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_pos_reg.col),
        .wdata (a_eff),
        .re    (pix_xfer),
        .raddr (pos.col),
        .rdata (ram_b_q)
    );

    // bypass when a read hits the column written back at the same edge
    assign a_eff = fwd_hit_reg ? fwd_a_reg : ram_a_q;
    assign b_eff = fwd_hit_reg ? fwd_b_reg : ram_b_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (pix_xfer)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= s1_adv && (pos.col == s1_pos_reg.col);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // stage payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (pix_xfer)
        begin
            s1_key_reg <= to_key(pix.interest);
            s1_pos_reg <= pos;
            fwd_a_reg  <= s1_key_reg;
            fwd_b_reg  <= a_eff;
        end
    end

    lmd_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (s1_adv),
        .top_key (b_eff),
        .mid_key (a_eff),
        .bot_key (s1_key_reg),
        .pos     (s1_pos_reg),
        .geom    (geom),
        .hit     (hit),
        .hit_col (hit_col),
        .hit_row (hit_row)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            res_valid_reg <= hit;
        end
        else if (feat.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            res_col_reg <= hit_col;
            res_row_reg <= hit_row;
        end
    end

    assign feat.valid = res_valid_reg;
    assign feat.col   = res_col_reg;
    assign feat.row   = res_row_reg;

    // a pixel transfer always lands in the stage register
    a_xfer_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        pix_xfer |=> s1_valid_reg)
        else $error("pixel transfer did not reach the stage register");

    // a new feature only follows a stage advance
    a_feat_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(feat.valid) |-> $past(s1_adv))
        else $error("feature appeared without a stage advance");

    // the border is at least one, so no feature can sit on the top row
    a_feat_not_top_row: assert property (@(posedge clk) disable iff (!rst_n)
        feat.valid |-> (feat.row != '0))
        else $error("feature reported on the top row");

endmodule

### verif/tb_local_maximum_3x3_detector.sv
// testbench of the 3x3 local maximum detector: random geometries and streams
import lmd_pkg::*;

typedef struct packed {
    logic [OUT_BITS-1:0] col;
    logic [OUT_BITS-1:0] row;
} peak_t;

// predicts the reported maxima and checks the result transfers against them
class peak_scoreboard;
    localparam int MAX_REPORTS = 10;

    // line stores: row above and the row above that, signed values
    logic signed [VALUE_BITS-1:0] prev_row  [MAX_WIDTH];
    logic signed [VALUE_BITS-1:0] older_row [MAX_WIDTH];
    // 3x3 neighbourhood, index col*3 + row, centre at 4
    logic signed [VALUE_BITS-1:0] patch [9];
    int unsigned col_pos;
    int unsigned row_pos;
    logic [DIM_BITS-1:0]    width_reg;
    logic [DIM_BITS-1:0]    height_reg;
    logic [BORDER_BITS-1:0] border_reg;
    peak_t expected_peaks [$];
    int unsigned pixels;
    int unsigned peaks;
    int unsigned writes;
    int unsigned mismatches;

    function new();
        int i;
        for (i = 0; i < MAX_WIDTH; i++)
        begin
            prev_row[i]  = {1'b1, {(VALUE_BITS-1){1'b0}}};
            older_row[i] = {1'b1, {(VALUE_BITS-1){1'b0}}};
        end
        for (i = 0; i < 9; i++)
            patch[i] = {1'b1, {(VALUE_BITS-1){1'b0}}};
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        border_reg = BORDER_RESET;
        pixels     = 0;
        peaks      = 0;
        writes     = 0;
        mismatches = 0;
    endfunction

    function void write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                            input logic [CFG_DATA_BITS-1:0] value);
        writes++;
        case (idx)
            REG_IMAGE_WIDTH:  width_reg  = value[DIM_BITS-1:0];
            REG_IMAGE_HEIGHT: height_reg = value[DIM_BITS-1:0];
            REG_BORDER_SIZE:  border_reg = value[BORDER_BITS-1:0];
            default: ;
        endcase
    endfunction

    function int unsigned width_now();
        if (width_reg < 3)
            return 3;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return width_reg;
    endfunction

    function int unsigned height_now();
        if (height_reg < 3)
            return 3;
        if (height_reg > ROW_LIMIT)
            return ROW_LIMIT;
        return height_reg;
    endfunction

    function int unsigned border_now();
        return (border_reg == 0) ? 1 : border_reg;
    endfunction

    function int unsigned pending();
        return expected_peaks.size();
    endfunction

    function void note_pixel(input logic signed [VALUE_BITS-1:0] value, input logic fs);
        int unsigned w, h, bd, c, r, x, y;
        int i;
        logic signed [VALUE_BITS-1:0] two_up, one_up;
        bit is_peak;
        peak_t found;
        w  = width_now();
        h  = height_now();
        bd = border_now();
        pixels++;
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        // column past a shrunk width ends the line, row past the height wraps
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        if (r >= h)
            r = 0;
        two_up = older_row[c];
        one_up = prev_row[c];
        older_row[c] = one_up;
        prev_row[c]  = value;
        for (i = 0; i < 6; i++)
            patch[i] = patch[i + 3];
        patch[6] = two_up;
        patch[7] = one_up;
        patch[8] = value;
        // centre is the pixel up and left of the one just in
        if (c >= 2 && r >= 2)
        begin
            x = c - 1;
            y = r - 1;
            if (x >= bd && x + bd < w && y >= bd && y + bd < h)
            begin
                is_peak = 1'b1;
                for (i = 0; i < 9; i++)
                    if (i != 4 && patch[i] > patch[4])
                        is_peak = 1'b0;
                if (is_peak)
                begin
                    found.col = OUT_BITS'(x);
                    found.row = OUT_BITS'(y);
                    expected_peaks.insert(expected_peaks.size(), found);
                end
            end
        end
        if (c + 1 >= w)
        begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            c++;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    function void check_peak(input logic [OUT_BITS-1:0] col, input logic [OUT_BITS-1:0] row);
        peak_t want;
        peaks++;
        if (expected_peaks.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("error: peak at col %0d row %0d with none expected", col, row);
            return;
        end
        want = expected_peaks.pop_front();
        if (want.col !== col || want.row !== row)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("error: peak %0d expected col %0d row %0d, got col %0d row %0d",
                         peaks, want.col, want.row, col, row);
        end
    endfunction
endclass

module tb_local_maximum_3x3_detector;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;   // no register behind it
    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam int RANDOM_PIXELS = 580;
    localparam int WIDE_PIXELS   = 40;     // part of one row at the widest line
    localparam int TALL_ROWS     = 20;     // rows sent at the tallest frame
    localparam int SETTLE_CYCLES = 32;     // pipeline flush before a register write
    localparam int QUIET_LIMIT   = 1000;   // many times the longest gap of a correct run

    typedef enum int unsigned {FULL_RANGE, NARROW_RANGE} value_mix_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lmd_cfg_if  cfg();
    lmd_pix_if  pix();
    lmd_feat_if feat();

    local_maximum_3x3_detector dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .pix   (pix),
        .feat  (feat)
    );

    peak_scoreboard board = new();
    int unsigned quiet_cycles = 0;
    bit src_calm  = 1'b0;
    bit sink_calm = 1'b0;

    always #2 clk = ~clk;

    // every transfer is observed here, register writes first so that a pixel
    // and a result in the same cycle see the settings they were made under
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                board.write_reg(cfg.index, cfg.data);
            if (pix.valid && pix.ready)
                board.note_pixel(pix.interest, pix.frame_start);
            if (feat.valid && feat.ready)
                board.check_peak(feat.col, feat.row);
            if ((cfg.valid && cfg.ready) || (pix.valid && pix.ready)
                || (feat.valid && feat.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog: too long without any transfer on any channel
    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("watchdog: no transfer for %0d cycles, %0d peaks still awaited",
                 QUIET_LIMIT, board.pending());
        $display("tb: failure");
        $finish;
    end

    // result side: random stall before each transfer, with calm stretches
    initial
    begin : result_sink
        int unsigned gap;
        feat.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 47) == 0)
                sink_calm = !sink_calm;
            gap = sink_calm ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                feat.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            feat.ready <= 1'b1;
            @(posedge clk);
            while (!feat.valid)
                @(posedge clk);
        end
    end

    // one register write; valid drops for a cycle after the transfer
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // one pixel transfer; valid stays high when the next one follows without a gap
    task automatic push_pixel(input logic signed [VALUE_BITS-1:0] value, input logic fs);
        int unsigned gap;
        if ($urandom_range(0, 63) == 0)
            src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid       <= 1'b1;
        pix.interest    <= value;
        pix.frame_start <= fs;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
    endtask

    // stop the stream, let every awaited peak arrive and the pipeline empty
    task automatic drain();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // narrow values give plenty of ties and flat plateaus
    function automatic logic signed [VALUE_BITS-1:0] draw_interest(input value_mix_t mix);
        if (mix == NARROW_RANGE)
            return VALUE_BITS'($urandom_range(0, 4)) - VALUE_BITS'(2);
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
        return VALUE_BITS'($urandom);
    endfunction

    task automatic send_pixels(input int unsigned count, input bit fs_first,
                               input bit fs_noise, input value_mix_t mix);
        int unsigned k;
        for (k = 0; k < count; k++)
            push_pixel(draw_interest(mix),
                       (k == 0 && fs_first) || (fs_noise && $urandom_range(0, 3) == 0));
    endtask

    // 3x3 frame: centre at the middle, corner is the last pixel (lower right)
    task automatic send_grid(input bit fs, input logic signed [VALUE_BITS-1:0] centre,
                             input logic signed [VALUE_BITS-1:0] rim,
                             input logic signed [VALUE_BITS-1:0] corner);
        int k;
        for (k = 0; k < 9; k++)
            push_pixel(k == 4 ? centre : (k == 8 ? corner : rim), fs && k == 0);
    endtask

    // write all three registers while idle; border data carries junk above bit 7
    task automatic apply_geometry(input logic [DIM_BITS-1:0] w_reg,
                                  input logic [DIM_BITS-1:0] h_reg,
                                  input logic [BORDER_BITS-1:0] b_reg, output bit grown);
        int unsigned old_w;
        drain();
        old_w = board.width_now();
        write_reg(REG_IMAGE_WIDTH, w_reg);
        write_reg(REG_IMAGE_HEIGHT, h_reg);
        write_reg(REG_BORDER_SIZE, {(CFG_DATA_BITS-BORDER_BITS)'($urandom), b_reg});
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
        grown = board.width_now() > old_w;
    endtask

    // mostly whole frames, some without the frame marker, some cut short,
    // some short bursts with stray markers
    task automatic send_random_frame(input bit force_fs);
        int unsigned w, h, kind;
        value_mix_t mix;
        w    = board.width_now();
        h    = board.height_now();
        kind = $urandom_range(0, 9);
        mix  = value_mix_t'($urandom_range(0, 1));
        if (kind <= 5)
            send_pixels(w * h, 1'b1, 1'b0, mix);
        else if (kind == 6)
            send_pixels(w * h, force_fs, 1'b0, mix);    // relies on the wrap
        else if (kind == 7)
            send_pixels($urandom_range(1, w * h - 1), 1'b1, 1'b0, mix);
        else
            send_pixels($urandom_range(1, 2 * w), force_fs, 1'b1, mix);
    endtask

    initial
    begin : stimulus
        int unsigned start_count;
        logic [DIM_BITS-1:0] w_reg, h_reg;
        logic [BORDER_BITS-1:0] b_reg;
        bit grown, fresh;
        pix.valid       = 1'b0;
        pix.interest    = '0;
        pix.frame_start = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = REG_IMAGE_WIDTH;
        cfg.data        = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: all registers zero, so a 3x3 image with one inner pixel and border 1
        apply_geometry('0, '0, '0, grown);
        send_grid(1'b1, 16'sd5, 16'sd5, 16'sd5);        // flat patch, ties still count
        send_grid(1'b0, VALUE_MAX, VALUE_MIN, VALUE_MIN); // no marker, position wrapped
        push_pixel(-16'sd1, 1'b1);                       // frame cut short after two pixels
        push_pixel(16'sd0, 1'b0);
        send_grid(1'b1, -16'sd1, VALUE_MIN, 16'sd0);     // lower right neighbour larger

        // random geometries; a wider line needs a fresh frame so that no
        // decision reads a line store entry that was never written
        start_count = board.pixels;
        while (board.pixels - start_count < RANDOM_PIXELS)
        begin
            w_reg = ($urandom_range(0, 7) == 0) ? DIM_BITS'($urandom_range(0, 2))
                                                 : DIM_BITS'($urandom_range(3, 12));
            h_reg = ($urandom_range(0, 7) == 0) ? DIM_BITS'($urandom_range(0, 2))
                                                 : DIM_BITS'($urandom_range(3, 8));
            case ($urandom_range(0, 11))
                0:       b_reg = '0;
                1:       b_reg = '1;
                default: b_reg = BORDER_BITS'($urandom_range(1, 3));
            endcase
            apply_geometry(w_reg, h_reg, b_reg, grown);
            fresh = grown || $urandom_range(0, 1);
            repeat ($urandom_range(1, 4))
            begin
                send_random_frame(fresh);
                fresh = 1'b0;
            end
        end

        // widest line: width register saturates, part of the top row only
        apply_geometry('1, DIM_BITS'(3), BORDER_BITS'(1), grown);
        send_pixels(WIDE_PIXELS, 1'b1, 1'b0, FULL_RANGE);
        // tallest frame: height register saturates, three columns, no wrap at small heights
        apply_geometry(DIM_BITS'(3), '1, BORDER_BITS'(1), grown);
        send_pixels(3 * TALL_ROWS, 1'b1, 1'b0, FULL_RANGE);

        drain();
        $display("summary: %0d pixel transfers, %0d peaks checked, %0d register writes",
                 board.pixels, board.peaks, board.writes);
        $display("summary: small frames up to 12x8, saturated geometry, %0d mismatches",
                 board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
